/* design/flux_limited_diffusion_coefficient_top_assert.svh */
// Assertion macros for the flux limited diffusion coefficient block.
// Used by the port checker; needs signals named clock and reset in scope.
`ifndef FLUX_LIMITED_DIFFUSION_COEFFICIENT_TOP_ASSERT_SVH
`define FLUX_LIMITED_DIFFUSION_COEFFICIENT_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define FDC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* design/fdc_pkg.sv */
// Shared types and constants of the flux limited diffusion coefficient block.
// No dependencies; used by the arithmetic units and the top level.
`default_nettype none
package fdc_pkg;
   localparam int WIDE_W = 128;
   localparam logic [62:0] SAT63 = 63'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;
endpackage
`default_nettype wire

/* design/fdc_div.sv */
// Restoring divider, one quotient bit per cycle over a 128-bit numerator.
// Depends on fdc_pkg; quotient saturates to 63 bits.
`default_nettype none
module fdc_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [fdc_pkg::WIDE_W-1:0]     num,
   input  wire logic [fdc_pkg::WIDE_W-1:0]     den,
   output logic [62:0]                         quot,
   output fdc_pkg::unit_status_type            stat
);
   logic [127:0] rem_ff, rem_in, n_ff, n_in, d_ff, d_in, q_ff, q_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [128:0] rem_sh;
   logic         ge;

   always_comb begin
      rem_sh  = {rem_ff, n_ff[127]};
      ge      = rem_sh >= {1'b0, d_ff};
      rem_in  = rem_ff;
      n_in    = n_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         n_in    = num;
         d_in    = den;
         q_in    = '0;
         cnt_in  = 7'd127;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 128'(rem_sh - {1'b0, d_ff}) : rem_sh[127:0];
         n_in   = {n_ff[126:0], 1'b0};
         q_in   = {q_ff[126:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot      = (|q_ff[127:63]) ? fdc_pkg::SAT63 : q_ff[62:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule
`default_nettype wire

/* design/fdc_mul.sv */
// 64 x 64 unsigned multiplier built from one 32 x 32 product per cycle.
// Depends on fdc_pkg; accumulates the four partial products into the full 128-bit product.
`default_nettype none
module fdc_mul (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [63:0]                 op_a,
   input  wire logic [63:0]                 op_b,
   output logic [fdc_pkg::WIDE_W-1:0]       prod,
   output fdc_pkg::unit_status_type         stat
);
   logic [63:0]  a_ff, a_in, b_ff, b_in, pp_ff, pp_in;
   logic [127:0] acc_ff, acc_in, pp_shift;
   logic [1:0]   sh_ff, sh_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  a_half, b_half;

   always_comb begin
      a_half = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      case (sh_ff)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd1:    pp_shift = {32'd0, pp_ff, 32'd0};
         2'd2:    pp_shift = {pp_ff, 64'd0};
         default: pp_shift = '0;
      endcase
      a_in    = a_ff;
      b_in    = b_ff;
      pp_in   = pp_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != 3'd4) begin
            pp_in = 64'(a_half) * 64'(b_half);
            sh_in = 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
         end
         if (cnt_ff != 3'd0) acc_in = acc_ff + pp_shift;
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign prod      = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule
`default_nettype wire

/* design/fdc_sqrt.sv */
// Digit-by-digit integer square root of a 128-bit value, one result bit a cycle.
// Depends on fdc_pkg; 64 iterations.
`default_nettype none
module fdc_sqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [fdc_pkg::WIDE_W-1:0]  radicand,
   output logic [63:0]                      root,
   output fdc_pkg::unit_status_type         stat
);
   logic [127:0] num_ff, num_in, res_ff, res_in, bit_ff, bit_in, trial;
   logic [5:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      trial   = res_ff + bit_ff;
      num_in  = num_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = radicand;
         res_in  = '0;
         bit_in  = 128'd1 << 126;
         cnt_in  = 6'd63;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (num_ff >= trial) begin
            num_in = num_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root      = res_ff[63:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule
`default_nettype wire

/* design/flux_limited_diffusion_coefficient_top.sv */
// Flux limited diffusion coefficient for one 2-D cell per transfer. The block
// takes one cell, then runs it through a sequencer that drives a shared
// bit-serial divider (up to five quotients), a 32x32-based multiplier (up to
// five products) and a square root unit. req_tready is high only while no
// cell is in work or waiting on the result side. Values are fixed point with
// FRACTION_BITS fraction bits and saturate; configuration is written through
// the APB port.
`default_nettype none
module flux_limited_diffusion_coefficient_top #(
   parameter int FRACTION_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // tdata: energy_center[63:0], energy_west[127:64], energy_east[191:128],
   //        energy_south[255:192], energy_north[319:256], extinction[382:320]
   input  wire logic [383:0] req_tdata,
   // tuser: edge_flags[3:0], first_cell[4]
   input  wire logic [4:0]   req_tuser,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: diffusion_coef[63:0], flux_fraction[126:64], max_flux_fraction[189:127]
   output logic [191:0]      rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [5:0]   csr_paddr,
   input  wire logic [63:0]  csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);
   localparam logic [62:0]  LAMBDA_THIRD = 63'((64'd1 << FRACTION_BITS) / 64'd3);
   localparam logic [127:0] R_LIMIT      = 128'd100000000 << FRACTION_BITS;
   localparam logic [127:0] ONE_SQ       = 128'd1 << (2 * FRACTION_BITS);
   localparam logic [62:0]  ONE_WIDTH    = 63'd1 << FRACTION_BITS;
   localparam logic [127:0] SIX          = 128'd6 << FRACTION_BITS;
   localparam logic [63:0]  TWO          = 64'd2 << FRACTION_BITS;

   typedef enum logic [2:0] {
      REG_LIMITER   = 3'd0,
      REG_DIRICHLET = 3'd1,
      REG_WALL_W    = 3'd2,
      REG_WALL_E    = 3'd3,
      REG_WALL_S    = 3'd4,
      REG_WALL_N    = 3'd5,
      REG_WIDTH_X   = 3'd6,
      REG_WIDTH_Y   = 3'd7
   } csr_index_type;

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_MIRROR = 15'b000000000000010,
      S_DIFF   = 15'b000000000000100,
      S_GX     = 15'b000000000001000,
      S_GY     = 15'b000000000010000,
      S_MGX    = 15'b000000000100000,
      S_MGY    = 15'b000000001000000,
      S_SQRT   = 15'b000000010000000,
      S_MDEN   = 15'b000000100000000,
      S_RDIV   = 15'b000001000000000,
      S_MRR    = 15'b000010000000000,
      S_LAM    = 15'b000100000000000,
      S_DCOEF  = 15'b001000000000000,
      S_MFF    = 15'b010000000000000,
      S_OUT    = 15'b100000000000000
   } state_type;

   // configuration
   logic               en_ff, en_in;
   logic [3:0]         dir_ff, dir_in;
   logic signed [63:0] wall_ff [4];
   logic signed [63:0] wall_in [4];
   logic [62:0]        wx_ff, wx_in, wy_ff, wy_in;
   csr_index_type      csr_idx;
   logic               csr_wr;

   // datapath
   state_type          state_ff, state_in;
   logic               started_ff, started_in;
   logic signed [63:0] e_ff, e_in;
   logic signed [63:0] nb_ff [4];
   logic signed [63:0] nb_in [4];
   logic [62:0]        chi_ff, chi_in;
   logic [3:0]         flags_ff, flags_in;
   logic               first_ff, first_in;
   logic [63:0]        dx_ff, dx_in, dy_ff, dy_in, g_ff, g_in;
   logic [62:0]        gx_ff, gx_in, gy_ff, gy_in, r_ff, r_in;
   logic [62:0]        lam_ff, lam_in, dc_ff, dc_in, fx_ff, fx_in, max_ff, max_in;
   logic [127:0]       sq_ff, sq_in, den_ff, den_in, p_shift;
   logic               big_ff, big_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [65:0] mirror;
   logic [63:0]        emin;
   logic [62:0]        fx_new;

   // arithmetic units; divider and multiplier are shared
   logic                     div_start, mul_start, sqrt_start;
   logic [127:0]             div_num, div_den;
   logic [62:0]              div_quot;
   logic [63:0]              mul_a, mul_b, sqrt_root;
   logic [127:0]             mul_p;
   fdc_pkg::unit_status_type div_stat, mul_stat, sqrt_stat;

   fdc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .quot(div_quot), .stat(div_stat)
   );
   fdc_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .prod(mul_p), .stat(mul_stat)
   );
   fdc_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .radicand(sq_ff),
      .root(sqrt_root), .stat(sqrt_stat)
   );

   // configuration port
   assign csr_idx    = csr_index_type'(csr_paddr[5:3]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      en_in  = en_ff;
      dir_in = dir_ff;
      wx_in  = wx_ff;
      wy_in  = wy_ff;
      for (int i = 0; i < 4; i++) wall_in[i] = wall_ff[i];
      if (csr_wr) begin
         case (csr_idx)
            REG_LIMITER:   en_in      = csr_pwdata[0];
            REG_DIRICHLET: dir_in     = csr_pwdata[3:0];
            REG_WALL_W:    wall_in[0] = csr_pwdata;
            REG_WALL_E:    wall_in[1] = csr_pwdata;
            REG_WALL_S:    wall_in[2] = csr_pwdata;
            REG_WALL_N:    wall_in[3] = csr_pwdata;
            REG_WIDTH_X:   wx_in      = csr_pwdata[62:0];
            REG_WIDTH_Y:   wy_in      = csr_pwdata[62:0];
            default:       en_in      = en_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_LIMITER:   csr_prdata = {63'd0, en_ff};
         REG_DIRICHLET: csr_prdata = {60'd0, dir_ff};
         REG_WALL_W:    csr_prdata = wall_ff[0];
         REG_WALL_E:    csr_prdata = wall_ff[1];
         REG_WALL_S:    csr_prdata = wall_ff[2];
         REG_WALL_N:    csr_prdata = wall_ff[3];
         REG_WIDTH_X:   csr_prdata = {1'b0, wx_ff};
         REG_WIDTH_Y:   csr_prdata = {1'b0, wy_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      e_in         = e_ff;
      chi_in       = chi_ff;
      flags_in     = flags_ff;
      first_in     = first_ff;
      for (int i = 0; i < 4; i++) nb_in[i] = nb_ff[i];
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      g_in         = g_ff;
      sq_in        = sq_ff;
      den_in       = den_ff;
      r_in         = r_ff;
      lam_in       = lam_ff;
      big_in       = big_ff;
      dc_in        = dc_ff;
      fx_in        = fx_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start    = 1'b0;
      mul_start    = 1'b0;
      sqrt_start   = 1'b0;
      div_num      = '0;
      div_den      = '0;
      mul_a        = '0;
      mul_b        = '0;
      mirror       = '0;
      emin         = (e_ff > 64'sd0) ? e_ff : 64'd1;
      p_shift      = mul_p >> FRACTION_BITS;
      fx_new       = (|p_shift[127:63]) ? fdc_pkg::SAT63 : p_shift[62:0];
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               e_in     = req_tdata[63:0];
               nb_in[0] = req_tdata[127:64];
               nb_in[1] = req_tdata[191:128];
               nb_in[2] = req_tdata[255:192];
               nb_in[3] = req_tdata[319:256];
               chi_in   = req_tdata[382:320];
               flags_in = req_tuser[3:0];
               first_in = req_tuser[4];
               state_in = S_MIRROR;
            end
         end
         S_MIRROR: begin
            // replace missing neighbors: wall mirror or the center itself
            for (int s = 0; s < 4; s++) begin
               mirror = {{2{wall_ff[s][63]}}, wall_ff[s]} + {{2{wall_ff[s][63]}}, wall_ff[s]}
                        - {{2{e_ff[63]}}, e_ff};
               if (flags_ff[s]) begin
                  if (!dir_ff[s]) nb_in[s] = e_ff;
                  else if (mirror[65:63] == 3'b000 || mirror[65:63] == 3'b111)
                     nb_in[s] = mirror[63:0];
                  else nb_in[s] = mirror[65] ? {1'b1, 63'd0} : {1'b0, fdc_pkg::SAT63};
               end
            end
            state_in = S_DIFF;
         end
         S_DIFF: begin
            dx_in    = (nb_ff[1] >= nb_ff[0]) ? 64'(nb_ff[1] - nb_ff[0])
                                             : 64'(nb_ff[0] - nb_ff[1]);
            dy_in    = (nb_ff[3] >= nb_ff[2]) ? 64'(nb_ff[3] - nb_ff[2])
                                             : 64'(nb_ff[2] - nb_ff[3]);
            state_in = S_GX;
         end
         S_GX: begin
            div_num = {64'd0, dx_ff} << (FRACTION_BITS - 1);
            div_den = {65'd0, wx_ff};
            if (!started_ff) begin
               if (wx_ff == 63'd0) begin
                  gx_in    = (dx_ff != 64'd0) ? fdc_pkg::SAT63 : 63'd0;
                  state_in = S_GY;
               end else begin
                  div_start  = 1'b1;
                  started_in = 1'b1;
               end
            end else if (div_stat.done) begin
               gx_in      = div_quot;
               started_in = 1'b0;
               state_in   = S_GY;
            end
         end
         S_GY: begin
            div_num = {64'd0, dy_ff} << (FRACTION_BITS - 1);
            div_den = {65'd0, wy_ff};
            if (!started_ff) begin
               if (wy_ff == 63'd0) begin
                  gy_in    = (dy_ff != 64'd0) ? fdc_pkg::SAT63 : 63'd0;
                  state_in = S_MGX;
               end else begin
                  div_start  = 1'b1;
                  started_in = 1'b1;
               end
            end else if (div_stat.done) begin
               gy_in      = div_quot;
               started_in = 1'b0;
               state_in   = S_MGX;
            end
         end
         S_MGX: begin
            mul_a = {1'b0, gx_ff};
            mul_b = {1'b0, gx_ff};
            if (!started_ff) begin
               mul_start  = 1'b1;
               started_in = 1'b1;
            end else if (mul_stat.done) begin
               sq_in      = mul_p;
               started_in = 1'b0;
               state_in   = S_MGY;
            end
         end
         S_MGY: begin
            mul_a = {1'b0, gy_ff};
            mul_b = {1'b0, gy_ff};
            if (!started_ff) begin
               mul_start  = 1'b1;
               started_in = 1'b1;
            end else if (mul_stat.done) begin
               sq_in      = sq_ff + mul_p;
               started_in = 1'b0;
               state_in   = S_SQRT;
            end
         end
         S_SQRT: begin
            if (!started_ff) begin
               sqrt_start = 1'b1;
               started_in = 1'b1;
            end else if (sqrt_stat.done) begin
               g_in       = sqrt_root;
               started_in = 1'b0;
               state_in   = S_MDEN;
            end
         end
         S_MDEN: begin
            mul_a = {1'b0, chi_ff};
            mul_b = emin;
            if (!started_ff) begin
               mul_start  = 1'b1;
               started_in = 1'b1;
            end else if (mul_stat.done) begin
               den_in     = p_shift;
               started_in = 1'b0;
               state_in   = S_RDIV;
            end
         end
         S_RDIV: begin
            div_num = {64'd0, g_ff} << FRACTION_BITS;
            div_den = den_ff;
            if (!started_ff) begin
               if (den_ff == 128'd0) begin
                  r_in     = (g_ff != 64'd0) ? fdc_pkg::SAT63 : 63'd0;
                  state_in = S_MRR;
               end else begin
                  div_start  = 1'b1;
                  started_in = 1'b1;
               end
            end else if (div_stat.done) begin
               r_in       = div_quot;
               started_in = 1'b0;
               state_in   = S_MRR;
            end
         end
         S_MRR: begin
            mul_a = {1'b0, r_ff};
            mul_b = {1'b0, r_ff};
            if (!started_ff) begin
               if (!en_ff) begin
                  lam_in   = LAMBDA_THIRD;
                  state_in = S_DCOEF;
               end else if ({65'd0, r_ff} > R_LIMIT) begin
                  big_in   = 1'b1;
                  state_in = S_LAM;
               end else begin
                  big_in     = 1'b0;
                  mul_start  = 1'b1;
                  started_in = 1'b1;
               end
            end else if (mul_stat.done) begin
               // denominator 6 + 3r + r*r
               sq_in      = SIX + {64'd0, r_ff, 1'b0} + {65'd0, r_ff} + p_shift;
               started_in = 1'b0;
               state_in   = S_LAM;
            end
         end
         S_LAM: begin
            if (big_ff) begin
               div_num = ONE_SQ;
               div_den = {65'd0, r_ff};
            end else begin
               div_num = {64'd0, 64'(TWO + {1'b0, r_ff})} << FRACTION_BITS;
               div_den = sq_ff;
            end
            if (!started_ff) begin
               div_start  = 1'b1;
               started_in = 1'b1;
            end else if (div_stat.done) begin
               lam_in     = div_quot;
               started_in = 1'b0;
               state_in   = S_DCOEF;
            end
         end
         S_DCOEF: begin
            div_num = {65'd0, lam_ff} << FRACTION_BITS;
            div_den = {65'd0, chi_ff};
            if (!started_ff) begin
               if (chi_ff == 63'd0) begin
                  dc_in    = fdc_pkg::SAT63;
                  state_in = S_MFF;
               end else begin
                  div_start  = 1'b1;
                  started_in = 1'b1;
               end
            end else if (div_stat.done) begin
               dc_in      = div_quot;
               started_in = 1'b0;
               state_in   = S_MFF;
            end
         end
         S_MFF: begin
            mul_a = {1'b0, lam_ff};
            mul_b = {1'b0, r_ff};
            if (!started_ff) begin
               mul_start  = 1'b1;
               started_in = 1'b1;
            end else if (mul_stat.done) begin
               fx_in = fx_new;
               if (first_ff || fx_new > max_ff) max_in = fx_new;
               started_in   = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            // hold the result until the transfer completes
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      e_ff     <= e_in;
      chi_ff   <= chi_in;
      flags_ff <= flags_in;
      first_ff <= first_in;
      for (int i = 0; i < 4; i++) nb_ff[i] <= nb_in[i];
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      g_ff     <= g_in;
      sq_ff    <= sq_in;
      den_ff   <= den_in;
      r_ff     <= r_in;
      lam_ff   <= lam_in;
      big_ff   <= big_in;
      dc_ff    <= dc_in;
      fx_ff    <= fx_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= '0;
         en_ff        <= 1'b1;
         dir_ff       <= '0;
         wx_ff        <= ONE_WIDTH;
         wy_ff        <= ONE_WIDTH;
         for (int i = 0; i < 4; i++) wall_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         max_ff       <= max_in;
         en_ff        <= en_in;
         dir_ff       <= dir_in;
         wx_ff        <= wx_in;
         wy_ff        <= wy_in;
         for (int i = 0; i < 4; i++) wall_ff[i] <= wall_in[i];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, max_ff, fx_ff, 1'b0, dc_ff};
endmodule
`default_nettype wire

/* design/fdc_checker.sv */
// Port-level checker for the flux limited diffusion coefficient block.
// Depends on the assertion macro header; bound to the top level below.
`default_nettype none
`include "flux_limited_diffusion_coefficient_top_assert.svh"
module fdc_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [191:0] rsp_tdata,
   input wire logic         csr_pready
);
   `FDC_ASSERT(a_busy_out, rsp_tvalid |-> !req_tready, "input taken while result pending")
   `FDC_ASSERT_NEXT(a_busy_in, req_tvalid && req_tready, !req_tready, "ready after transfer")
   `FDC_ASSERT(a_max, rsp_tvalid |-> (rsp_tdata[189:127] >= rsp_tdata[126:64]), "max below value")
   `FDC_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
   `FDC_ASSERT(a_pready, csr_pready, "pready low")
endmodule

bind flux_limited_diffusion_coefficient_top fdc_checker u_fdc_checker (.*);
`default_nettype wire
